/* rtl/core/step_position_edge_latch_core_macros.svh */
// ---------------------------------------------------------------------------
// Step position edge latch: assertion macros
// Concurrent property shorthands used by the core's state update (sple_update).
// ---------------------------------------------------------------------------
`ifndef STEP_POSITION_EDGE_LATCH_CORE_MACROS_SVH
`define STEP_POSITION_EDGE_LATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sple property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sple property failed");

`endif

/* rtl/core/sple_pkg.sv */
// ---------------------------------------------------------------------------
// Step position edge latch package
// Shared types, opcodes and register indices of the core.
// ---------------------------------------------------------------------------
`default_nettype none

package sple_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam int OPCODE_BITS    = 3;
    localparam int FIELD_BITS     = 32;
    localparam int DEBOUNCE_BITS  = 16;
    localparam int CAPACITY_BITS  = 10;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [OPCODE_BITS-1:0] OP_STEP       = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_ZERO       = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_SHIFT      = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_ARM_LATCH  = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_ARM_CENSUS = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_DISARM     = 3'd5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_COUNT = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_CAPACITY  = 4'd1;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd1;
    localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 10'd64;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic                   direction_forward;
        logic                   sensor_active;
        logic                   want_active;
        logic [FIELD_BITS-1:0]  shift_amount;
    } t_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0]    position;
        logic                     latch_seen;
        logic [FIELD_BITS-1:0]    latch_edge_position;
        logic                     edge_valid;
        logic [FIELD_BITS-1:0]    edge_position;
        logic                     edge_level;
        logic [CAPACITY_BITS-1:0] edge_count;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/sple_in_stage.sv */
// ---------------------------------------------------------------------------
// Step position edge latch: input register
// Holds one accepted request until the update stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sple_in_stage
    import sple_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign w_load     = i_in_valid && (!r_valid || i_take);
    assign o_in_stall = r_valid && !i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sple_update.sv */
// ---------------------------------------------------------------------------
// Step position edge latch: state update
// Position counter, debounced latch and edge census, updated once per request.
// ---------------------------------------------------------------------------
`default_nettype none

`include "step_position_edge_latch_core_macros.svh"

module sple_update
    import sple_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fire,
    input  wire t_item                    i_item,
    input  wire logic [DEBOUNCE_BITS-1:0] i_debounce_count,
    input  wire logic [CAPACITY_BITS-1:0] i_edge_capacity,
    output t_result                       o_result
);

    localparam int PB = POSITION_BITS;

    logic [PB-1:0]            r_step_position,  n_step_position;
    logic                     r_latch_armed,    n_latch_armed;
    logic                     r_latch_level,    n_latch_level;
    logic                     r_latch_found,    n_latch_found;
    logic [PB-1:0]            r_latch_position, n_latch_position;
    logic [DEBOUNCE_BITS-1:0] r_latch_run,      n_latch_run;
    logic                     r_latch_dir,      n_latch_dir;
    logic                     r_census_armed,   n_census_armed;
    logic                     r_census_level,   n_census_level;
    logic [DEBOUNCE_BITS-1:0] r_census_run,     n_census_run;
    logic [CAPACITY_BITS-1:0] r_census_edges,   n_census_edges;

    logic [DEBOUNCE_BITS-1:0] w_eff;
    logic [PB-1:0]            w_back;
    logic [PB-1:0]            w_delta;
    logic [PB-1:0]            w_step_edge;
    logic [PB-1:0]            w_stored_edge;
    logic [PB-1:0]            w_latch_edge;
    logic [DEBOUNCE_BITS-1:0] w_latch_inc;
    logic [DEBOUNCE_BITS-1:0] w_census_inc;
    logic                     w_just_found;
    logic                     w_ev;
    logic [PB-1:0]            w_epos;

    assign w_eff  = (i_debounce_count == '0) ? DEBOUNCE_BITS'(1) : i_debounce_count;
    assign w_back = PB'(w_eff - DEBOUNCE_BITS'(1));

    // Offset from the pre-step position to the start of the confirming run.
    assign w_delta     = i_item.direction_forward ? (PB'(1) - w_back) : (w_back - PB'(1));
    assign w_step_edge = r_step_position + w_delta;
    assign w_stored_edge = r_latch_dir ? (r_latch_position - w_back)
                                       : (r_latch_position + w_back);

    assign w_latch_inc  = (r_latch_run == '1) ? r_latch_run : r_latch_run + DEBOUNCE_BITS'(1);
    assign w_census_inc = (r_census_run == '1) ? r_census_run
                                               : r_census_run + DEBOUNCE_BITS'(1);

    always_comb begin
        n_step_position  = r_step_position;
        n_latch_armed    = r_latch_armed;
        n_latch_level    = r_latch_level;
        n_latch_found    = r_latch_found;
        n_latch_position = r_latch_position;
        n_latch_run      = r_latch_run;
        n_latch_dir      = r_latch_dir;
        n_census_armed   = r_census_armed;
        n_census_level   = r_census_level;
        n_census_run     = r_census_run;
        n_census_edges   = r_census_edges;
        w_just_found     = 1'b0;
        w_ev             = 1'b0;
        w_epos           = '0;
        case (i_item.opcode)
            OP_STEP: begin
                n_step_position = i_item.direction_forward ? r_step_position + PB'(1)
                                                           : r_step_position - PB'(1);
                if (r_latch_armed && !r_latch_found) begin
                    if (i_item.sensor_active == r_latch_level) begin
                        n_latch_run = w_latch_inc;
                        if (w_latch_inc >= w_eff) begin
                            n_latch_found    = 1'b1;
                            n_latch_position = n_step_position;
                            n_latch_dir      = i_item.direction_forward;
                            w_just_found     = 1'b1;
                        end
                    end else begin
                        n_latch_run = '0;
                    end
                end else if (r_census_armed) begin
                    if (i_item.sensor_active != r_census_level) begin
                        n_census_run = w_census_inc;
                        if (w_census_inc >= w_eff) begin
                            n_census_level = i_item.sensor_active;
                            n_census_run   = '0;
                            if (r_census_edges < i_edge_capacity) begin
                                w_ev           = 1'b1;
                                w_epos         = w_step_edge;
                                n_census_edges = r_census_edges + CAPACITY_BITS'(1);
                            end
                        end
                    end else begin
                        n_census_run = '0;
                    end
                end
            end
            OP_ZERO: begin
                n_step_position = '0;
            end
            OP_SHIFT: begin
                n_step_position = r_step_position - PB'(signed'(i_item.shift_amount));
            end
            OP_ARM_LATCH: begin
                n_latch_level    = i_item.want_active;
                n_latch_found    = 1'b0;
                n_latch_position = '0;
                n_latch_run      = '0;
                n_latch_dir      = 1'b0;
                n_latch_armed    = 1'b1;
            end
            OP_ARM_CENSUS: begin
                n_census_edges = '0;
                n_census_run   = '0;
                n_census_level = i_item.sensor_active;
                n_census_armed = 1'b1;
            end
            OP_DISARM: begin
                n_latch_armed  = 1'b0;
                n_census_armed = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign w_latch_edge = w_just_found ? w_step_edge : w_stored_edge;

    always_comb begin
        o_result.position            = FIELD_BITS'(signed'(n_step_position));
        o_result.latch_seen          = n_latch_found;
        o_result.latch_edge_position = n_latch_found ? FIELD_BITS'(signed'(w_latch_edge))
                                                     : '0;
        o_result.edge_valid          = w_ev;
        o_result.edge_position       = w_ev ? FIELD_BITS'(signed'(w_epos)) : '0;
        o_result.edge_level          = w_ev && i_item.sensor_active;
        o_result.edge_count          = n_census_edges;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_position  <= '0;
            r_latch_armed    <= 1'b0;
            r_latch_level    <= 1'b0;
            r_latch_found    <= 1'b0;
            r_latch_position <= '0;
            r_latch_run      <= '0;
            r_latch_dir      <= 1'b0;
            r_census_armed   <= 1'b0;
            r_census_level   <= 1'b0;
            r_census_run     <= '0;
            r_census_edges   <= '0;
        end else if (i_fire) begin
            r_step_position  <= n_step_position;
            r_latch_armed    <= n_latch_armed;
            r_latch_level    <= n_latch_level;
            r_latch_found    <= n_latch_found;
            r_latch_position <= n_latch_position;
            r_latch_run      <= n_latch_run;
            r_latch_dir      <= n_latch_dir;
            r_census_armed   <= n_census_armed;
            r_census_level   <= n_census_level;
            r_census_run     <= n_census_run;
            r_census_edges   <= n_census_edges;
        end
    end

    `SPLE_ASSERT_IMPL(a_edge_needs_census, i_clk, i_rst_n, i_fire && o_result.edge_valid, r_census_armed && (r_census_edges < i_edge_capacity))
    `SPLE_ASSERT_IMPL(a_latch_blocks_census, i_clk, i_rst_n, i_fire && r_latch_armed && !r_latch_found, !o_result.edge_valid)
    `SPLE_ASSERT_NEXT(a_disarm_clears, i_clk, i_rst_n, i_fire && (i_item.opcode == OP_DISARM), !r_latch_armed && !r_census_armed)
    `SPLE_ASSERT_NEXT(a_capture_holds, i_clk, i_rst_n, r_latch_found && !(i_fire && (i_item.opcode == OP_ARM_LATCH)), r_latch_found && $stable(r_latch_position))

endmodule

`default_nettype wire

/* rtl/core/sple_out_stage.sv */
// ---------------------------------------------------------------------------
// Step position edge latch: result register
// Holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sple_out_stage
    import sple_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_out_stall,
    output logic         o_take,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_take      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/step_position_edge_latch_core.sv */
// ---------------------------------------------------------------------------
// Step position edge latch core
// Microstep position counter with a debounced home latch and an edge census.
// ---------------------------------------------------------------------------
// One request per step pulse or control command enters on the input channel
// (i_in_valid / o_in_stall) and yields exactly one result on the output
// channel (o_out_valid / i_out_stall). A request is taken at a clock edge at
// which valid is high and stall is low.
// A request accepted at a clock edge is held in the input register, passes
// through the state update once the result register can take it, and is then
// presented from the result register. The update logic is a single
// pass, so one request is accepted in every cycle while the result register
// is free or being emptied.
// When the receiver stalls, the result register holds its contents, the
// input register fills and o_in_stall rises; nothing is dropped.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the debounce
// count (index 0) and the census capacity (index 1); it is always ready and
// should only be used while no request is in flight.
// Synchronous reset clears the position, both arming bits, the latch and the
// census, and loads a debounce count of 1 and a capacity of 64.
// ---------------------------------------------------------------------------
`default_nettype none

module step_position_edge_latch_core
    import sple_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [OPCODE_BITS-1:0]    i_opcode,
    input  wire logic                      i_direction_forward,
    input  wire logic                      i_sensor_active,
    input  wire logic                      i_want_active,
    input  wire logic signed [FIELD_BITS-1:0] i_shift_amount,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [FIELD_BITS-1:0]   o_position,
    output logic                           o_latch_seen,
    output logic signed [FIELD_BITS-1:0]   o_latch_edge_position,
    output logic                           o_edge_valid,
    output logic signed [FIELD_BITS-1:0]   o_edge_position,
    output logic                           o_edge_level,
    output logic [CAPACITY_BITS-1:0]       o_edge_count,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [DEBOUNCE_BITS-1:0] r_debounce_count;
    logic [CAPACITY_BITS-1:0] r_edge_capacity;

    t_item   w_in_item;
    t_item   w_stage_item;
    t_result w_update_result;
    t_result w_out_result;
    logic    w_stage_valid;
    logic    w_take;
    logic    w_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_count <= DEBOUNCE_RESET;
            r_edge_capacity  <= CAPACITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_COUNT: r_debounce_count <= i_cfg_data;
                REG_EDGE_CAPACITY:  r_edge_capacity  <= i_cfg_data[CAPACITY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_in_item.opcode            = i_opcode;
        w_in_item.direction_forward = i_direction_forward;
        w_in_item.sensor_active     = i_sensor_active;
        w_in_item.want_active       = i_want_active;
        w_in_item.shift_amount      = i_shift_amount;
    end

    assign w_fire = w_stage_valid && w_take;

    sple_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (w_in_item),
        .i_take     (w_take),
        .o_valid    (w_stage_valid),
        .o_item     (w_stage_item)
    );

    sple_update #(
        .POSITION_BITS (POSITION_BITS)
    ) u_update (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_item           (w_stage_item),
        .i_debounce_count (r_debounce_count),
        .i_edge_capacity  (r_edge_capacity),
        .o_result         (w_update_result)
    );

    sple_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_result    (w_update_result),
        .i_out_stall (i_out_stall),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_position            = w_out_result.position;
    assign o_latch_seen          = w_out_result.latch_seen;
    assign o_latch_edge_position = w_out_result.latch_edge_position;
    assign o_edge_valid          = w_out_result.edge_valid;
    assign o_edge_position       = w_out_result.edge_position;
    assign o_edge_level          = w_out_result.edge_level;
    assign o_edge_count          = w_out_result.edge_count;

endmodule

`default_nettype wire

/* dv/step_position_edge_latch_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Step position edge latch result checker
// Watches the request, result and register channels of the core, keeps its
// own copy of the position, latch and census state, predicts one result per
// accepted request and compares every accepted result field by field.
// ---------------------------------------------------------------------------
module step_position_edge_latch_checker
    import sple_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic [OPCODE_BITS-1:0]    i_opcode,
    input  wire logic                      i_direction_forward,
    input  wire logic                      i_sensor_active,
    input  wire logic                      i_want_active,
    input  wire logic [FIELD_BITS-1:0]     i_shift_amount,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic [FIELD_BITS-1:0]     i_position,
    input  wire logic                      i_latch_seen,
    input  wire logic [FIELD_BITS-1:0]     i_latch_edge_position,
    input  wire logic                      i_edge_valid,
    input  wire logic [FIELD_BITS-1:0]     i_edge_position,
    input  wire logic                      i_edge_level,
    input  wire logic [CAPACITY_BITS-1:0]  i_edge_count,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending_count
);

    logic [DEBOUNCE_BITS-1:0] debounce;
    logic [CAPACITY_BITS-1:0] capacity;
    logic [FIELD_BITS-1:0]    position;
    logic                     latch_armed;
    logic                     latch_level;
    logic                     latch_found;
    logic                     latch_forward;
    logic [FIELD_BITS-1:0]    latch_position;
    logic [DEBOUNCE_BITS-1:0] latch_run;
    logic                     census_armed;
    logic                     census_level;
    logic [DEBOUNCE_BITS-1:0] census_run;
    logic [CAPACITY_BITS-1:0] census_edges;
    t_result                  awaited_reports[$];
    int                       fails = 0;

    function automatic logic [DEBOUNCE_BITS-1:0] confirm_samples();
        return (debounce == '0) ? DEBOUNCE_BITS'(1) : debounce;
    endfunction

    // Moves a confirming position back to the first sample of its run.
    function automatic logic [FIELD_BITS-1:0] run_start(input logic [FIELD_BITS-1:0] pos,
                                                         input logic forward);
        logic [FIELD_BITS-1:0] back;
        back = FIELD_BITS'(confirm_samples()) - FIELD_BITS'(1);
        return forward ? pos - back : pos + back;
    endfunction

    function automatic t_result track_request(input t_item req);
        t_result rep;
        rep = '0;
        case (req.opcode)
            OP_STEP: begin
                position = req.direction_forward ? position + FIELD_BITS'(1)
                                                 : position - FIELD_BITS'(1);
                if (latch_armed && !latch_found) begin
                    if (req.sensor_active == latch_level) begin
                        if (latch_run != '1) latch_run = latch_run + DEBOUNCE_BITS'(1);
                        if (latch_run >= confirm_samples()) begin
                            latch_found = 1'b1;
                            latch_position = position;
                            latch_forward = req.direction_forward;
                        end
                    end else begin
                        latch_run = '0;
                    end
                end else if (census_armed) begin
                    if (req.sensor_active != census_level) begin
                        if (census_run != '1) census_run = census_run + DEBOUNCE_BITS'(1);
                        if (census_run >= confirm_samples()) begin
                            census_level = req.sensor_active;
                            census_run = '0;
                            if (census_edges < capacity) begin
                                rep.edge_valid = 1'b1;
                                rep.edge_position = run_start(position, req.direction_forward);
                                rep.edge_level = req.sensor_active;
                                census_edges = census_edges + CAPACITY_BITS'(1);
                            end
                        end
                    end else begin
                        census_run = '0;
                    end
                end
            end
            OP_ZERO: begin
                position = '0;
            end
            OP_SHIFT: begin
                position = position - req.shift_amount;
            end
            OP_ARM_LATCH: begin
                latch_level = req.want_active;
                latch_found = 1'b0;
                latch_position = '0;
                latch_run = '0;
                latch_forward = 1'b0;
                latch_armed = 1'b1;
            end
            OP_ARM_CENSUS: begin
                census_edges = '0;
                census_run = '0;
                census_level = req.sensor_active;
                census_armed = 1'b1;
            end
            OP_DISARM: begin
                latch_armed = 1'b0;
                census_armed = 1'b0;
            end
            default: ;
        endcase
        rep.position = position;
        rep.latch_seen = latch_found;
        rep.latch_edge_position = latch_found ? run_start(latch_position, latch_forward) : '0;
        rep.edge_count = census_edges;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
                               input logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   req;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            debounce = DEBOUNCE_RESET;
            capacity = CAPACITY_RESET;
            position = '0;
            latch_armed = 1'b0;
            latch_level = 1'b0;
            latch_found = 1'b0;
            latch_forward = 1'b0;
            latch_position = '0;
            latch_run = '0;
            census_armed = 1'b0;
            census_level = 1'b0;
            census_run = '0;
            census_edges = '0;
            awaited_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEBOUNCE_COUNT: debounce = i_cfg_data[DEBOUNCE_BITS-1:0];
                    REG_EDGE_CAPACITY:  capacity = i_cfg_data[CAPACITY_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.position = i_position;
                got.latch_seen = i_latch_seen;
                got.latch_edge_position = i_latch_edge_position;
                got.edge_valid = i_edge_valid;
                got.edge_position = i_edge_position;
                got.edge_level = i_edge_level;
                got.edge_count = i_edge_count;
                if (awaited_reports.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual position %h",
                             $time, got.position);
                end else begin
                    want = awaited_reports.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("latch_seen", FIELD_BITS'(want.latch_seen),
                                FIELD_BITS'(got.latch_seen));
                    check_field("latch_edge_position", want.latch_edge_position,
                                got.latch_edge_position);
                    check_field("edge_valid", FIELD_BITS'(want.edge_valid),
                                FIELD_BITS'(got.edge_valid));
                    check_field("edge_position", want.edge_position, got.edge_position);
                    check_field("edge_level", FIELD_BITS'(want.edge_level),
                                FIELD_BITS'(got.edge_level));
                    check_field("edge_count", FIELD_BITS'(want.edge_count),
                                FIELD_BITS'(got.edge_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                req.opcode = i_opcode;
                req.direction_forward = i_direction_forward;
                req.sensor_active = i_sensor_active;
                req.want_active = i_want_active;
                req.shift_amount = i_shift_amount;
                awaited_reports.push_back(track_request(req));
            end
        end
        o_fail_count <= fails;
        o_pending_count <= awaited_reports.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Step position edge latch testbench
// Drives directed and random step and control requests into the core under
// bursty sending and a varying result stall, rewrites the debounce count and
// census capacity between phases, and leaves the checking to the checker.
// ---------------------------------------------------------------------------
module tb;
    import sple_pkg::*;

    localparam logic [OPCODE_BITS-1:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [OPCODE_BITS-1:0] OP_SPARE_HIGH = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [OPCODE_BITS-1:0]       opcode = OP_STEP;
    logic                         direction_forward = 1'b0;
    logic                         sensor_active = 1'b0;
    logic                         want_active = 1'b0;
    logic signed [FIELD_BITS-1:0] shift_amount = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [FIELD_BITS-1:0] position;
    logic                         latch_seen;
    logic signed [FIELD_BITS-1:0] latch_edge_position;
    logic                         edge_valid;
    logic signed [FIELD_BITS-1:0] edge_position;
    logic                         edge_level;
    logic [CAPACITY_BITS-1:0]     edge_count;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_DEBOUNCE_COUNT;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
    int                           fail_count;
    int                           pending_count;

    int                           cycle_count = 0;
    int                           burst_left = 0;
    int                           sensor_left = 0;
    logic                         sensor_level = 1'b0;
    logic                         heading_forward = 1'b1;
    logic [DEBOUNCE_BITS-1:0]     cur_debounce = DEBOUNCE_RESET;

    step_position_edge_latch_core u_top (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_opcode              (opcode),
        .i_direction_forward   (direction_forward),
        .i_sensor_active       (sensor_active),
        .i_want_active         (want_active),
        .i_shift_amount        (shift_amount),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_position            (position),
        .o_latch_seen          (latch_seen),
        .o_latch_edge_position (latch_edge_position),
        .o_edge_valid          (edge_valid),
        .o_edge_position       (edge_position),
        .o_edge_level          (edge_level),
        .o_edge_count          (edge_count),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    step_position_edge_latch_checker u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .i_in_stall            (in_stall),
        .i_opcode              (opcode),
        .i_direction_forward   (direction_forward),
        .i_sensor_active       (sensor_active),
        .i_want_active         (want_active),
        .i_shift_amount        (shift_amount),
        .i_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .i_position            (position),
        .i_latch_seen          (latch_seen),
        .i_latch_edge_position (latch_edge_position),
        .i_edge_valid          (edge_valid),
        .i_edge_position       (edge_position),
        .i_edge_level          (edge_level),
        .i_edge_count          (edge_count),
        .i_cfg_valid           (cfg_valid),
        .i_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .o_fail_count          (fail_count),
        .o_pending_count       (pending_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver alternates between free running, light, heavy and solid stalls.
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(2, 30) : $urandom_range(5, 80);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_request(input logic [OPCODE_BITS-1:0] op, input logic forward,
                                input logic sensor, input logic want,
                                input logic [FIELD_BITS-1:0] shift);
        opcode <= op;
        direction_forward <= forward;
        sensor_active <= sensor;
        want_active <= want;
        shift_amount <= shift;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic await_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // The sensor holds each level for a random run of up to four steps more than
    // the debounce count, but never more than fourteen steps.
    function automatic logic next_sensor();
        int longest;
        if (sensor_left == 0) begin
            sensor_level = ~sensor_level;
            longest = (cur_debounce > 10) ? 14 : int'(cur_debounce) + 4;
            sensor_left = $urandom_range(1, longest);
        end
        sensor_left--;
        return sensor_level;
    endfunction

    task automatic send_random_request();
        int pick;
        logic [OPCODE_BITS-1:0] op;
        logic [FIELD_BITS-1:0] shift;
        logic sensor;
        pick = $urandom_range(0, 99);
        if (pick < 78)      op = OP_STEP;
        else if (pick < 82) op = OP_ARM_LATCH;
        else if (pick < 87) op = OP_ARM_CENSUS;
        else if (pick < 89) op = OP_DISARM;
        else if (pick < 92) op = OP_ZERO;
        else if (pick < 97) op = OP_SHIFT;
        else                op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LOW : OP_SPARE_HIGH;
        if ($urandom_range(0, 15) == 0) heading_forward = ~heading_forward;
        shift = ($urandom_range(0, 1) == 0) ? $urandom : FIELD_BITS'($urandom_range(0, 40) - 20);
        sensor = (op == OP_STEP) ? next_sensor() : 1'($urandom_range(0, 1));
        send_request(op, heading_forward, sensor, 1'($urandom_range(0, 1)), shift);
    endtask

    task automatic run_phase(input logic [DEBOUNCE_BITS-1:0] debounce,
                             input logic [CAPACITY_BITS-1:0] capacity, input int count);
        await_quiet();
        write_register(REG_DEBOUNCE_COUNT, CFG_DATA_BITS'(debounce));
        write_register(REG_EDGE_CAPACITY, CFG_DATA_BITS'(capacity));
        cfg_valid <= 1'b0;
        cur_debounce = debounce;
        repeat (count) begin
            send_random_request();
            pace_sender();
            if ($urandom_range(0, 149) == 0) await_quiet();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_STEP, 1'b1, 1'b0, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_SHIFT, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
        send_request(OP_STEP, 1'b1, 1'b0, 1'b0, 32'h0);
        pace_sender();
        send_request(OP_SHIFT, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        send_request(OP_SHIFT, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_ZERO, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_ARM_CENSUS, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_ARM_LATCH, 1'b0, 1'b0, 1'b1, 32'h0);
        // Census ignores steps only until the latch confirms on the second one.
        send_request(OP_STEP, 1'b1, 1'b0, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b1, 1'b1, 1'b0, 32'h0);
        pace_sender();
        send_request(OP_STEP, 1'b1, 1'b1, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_DISARM, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_SPARE_LOW, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_SPARE_HIGH, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_ARM_LATCH, 1'b1, 1'b1, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b0, 1'b0, 1'b0, 32'h0);
        send_request(OP_ARM_CENSUS, 1'b0, 1'b1, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b1, 1'b1, 1'b0, 32'h0);
        send_request(OP_STEP, 1'b1, 1'b0, 1'b0, 32'h0);
        pace_sender();

        run_phase(16'd3, 10'd4, 130);
        run_phase(16'd0, 10'd1023, 130);
        run_phase(16'd2, 10'd0, 100);
        run_phase(16'd65535, 10'd1023, 40);
        run_phase(16'd1, 10'd1, 120);
        run_phase(16'd5, 10'd17, 130);
        run_phase(16'd2, 10'd64, 100);

        await_quiet();
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
